// ===== rtl/core/teor_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and register codes for the owner rank block
package teor_pkg;

  localparam int LW       = 31;  // mode length and coordinate width
  localparam int GW       = 7;   // grid size width
  localparam int RW       = 24;  // owner rank width
  localparam int NUM_SLOTS = 4;  // dimensions present on the ports
  localparam int NUM_DIMS_DEF = 4;
  localparam int AW       = 5;   // cfg byte address width
  localparam int DW       = 32;  // cfg data width
  localparam int IDXW     = 3;   // register index width

  // register indexes
  localparam logic [IDXW-1:0] REG_MODE_LENGTH_0 = 3'd0;
  localparam logic [IDXW-1:0] REG_GRID_SIZE_0   = 3'd4;

  typedef struct packed {
    logic [LW-1:0] coord_0;
    logic [LW-1:0] coord_1;
    logic [LW-1:0] coord_2;
    logic [LW-1:0] coord_3;
  } in_data_t;

  typedef struct packed {
    logic [RW-1:0] owner_rank;
    logic          out_of_range;
  } out_data_t;

  // one dimension's working word as it moves through the divider cells
  typedef struct packed {
    logic [LW-1:0] num;     // partial remainder
    logic [LW-1:0] dvs;     // divisor
    logic [LW-1:0] quo;     // quotient bits so far
    logic [LW-1:0] coord;
    logic [GW-1:0] grid;
    logic [GW-1:0] rsave;   // block offset added after the second division
    logic          zero_q;
    logic          bad;
  } lane_t;

  typedef struct packed {
    logic [GW-1:0] blk;
    logic [GW-1:0] grid;
    logic          bad;
  } lane_res_t;

endpackage

// ===== rtl/core/teor_div_cell.sv =====
`timescale 1ns / 1ps
// one restoring division step: subtracts the divisor shifted by SHIFT if it fits
module teor_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            en,
  input  teor_pkg::lane_t d_in,
  output teor_pkg::lane_t d_out
);

  logic [2*teor_pkg::LW-1:0] big;
  logic                      fit;
  teor_pkg::lane_t           nxt;

  always_comb begin
    big = {{teor_pkg::LW{1'b0}}, d_in.dvs} << SHIFT;
    fit = (big[2*teor_pkg::LW-1:teor_pkg::LW] == '0) &&
          (d_in.num >= big[teor_pkg::LW-1:0]);
    nxt = d_in;
    if (fit) begin
      nxt.num        = d_in.num - big[teor_pkg::LW-1:0];
      nxt.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== rtl/core/teor_lane.sv =====
`timescale 1ns / 1ps
// block index of one dimension: length/grid division, edge split, index division
module teor_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [teor_pkg::LW-1:0]  coord,
  input  logic [teor_pkg::LW-1:0]  mode_length,
  input  logic [teor_pkg::GW-1:0]  grid_size,
  output teor_pkg::lane_res_t      res
);

  localparam int QW = 7;  // block index never exceeds the grid size

  teor_pkg::lane_t c1 [0:teor_pkg::LW];
  teor_pkg::lane_t c2 [0:QW];
  teor_pkg::lane_t mid_nxt;
  teor_pkg::lane_res_t res_nxt;

  logic [teor_pkg::LW:0]              q_inc;
  logic [teor_pkg::LW+teor_pkg::GW:0] edge_v;
  logic                               lt;

  always_comb begin
    c1[0]        = '0;
    c1[0].num    = mode_length;
    c1[0].grid   = (grid_size == '0) ? teor_pkg::GW'(1) : grid_size;
    c1[0].dvs    = {{(teor_pkg::LW-teor_pkg::GW){1'b0}}, c1[0].grid};
    c1[0].coord  = coord;
    c1[0].bad    = (coord >= mode_length);
  end

  // quotient and remainder of length over grid, one bit a cell
  for (genvar i = 0; i < teor_pkg::LW; i++) begin : g_c1
    teor_div_cell #(.SHIFT(teor_pkg::LW-1-i)) u_cell (
      .clk(clk), .en(en), .d_in(c1[i]), .d_out(c1[i+1])
    );
  end

  // split at the end of the larger blocks
  always_comb begin
    q_inc   = {1'b0, c1[teor_pkg::LW].quo} + 1'b1;
    edge_v  = c1[teor_pkg::LW].num[teor_pkg::GW-1:0] * q_inc;
    lt      = {{(teor_pkg::GW+1){1'b0}}, c1[teor_pkg::LW].coord} < edge_v;
    mid_nxt = c1[teor_pkg::LW];
    mid_nxt.quo    = '0;
    mid_nxt.zero_q = (c1[teor_pkg::LW].quo == '0);
    if (lt) begin
      mid_nxt.num   = c1[teor_pkg::LW].coord;
      mid_nxt.dvs   = q_inc[teor_pkg::LW-1:0];
      mid_nxt.rsave = '0;
    end else begin
      mid_nxt.num   = c1[teor_pkg::LW].coord - edge_v[teor_pkg::LW-1:0];
      mid_nxt.dvs   = c1[teor_pkg::LW].quo;
      mid_nxt.rsave = c1[teor_pkg::LW].num[teor_pkg::GW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2[0] <= mid_nxt;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_c2
    teor_div_cell #(.SHIFT(QW-1-i)) u_cell (
      .clk(clk), .en(en), .d_in(c2[i]), .d_out(c2[i+1])
    );
  end

  always_comb begin
    res_nxt.grid = c2[QW].grid;
    res_nxt.bad  = c2[QW].bad;
    res_nxt.blk  = c2[QW].zero_q ? '0 : (c2[QW].quo[QW-1:0] + c2[QW].rsave);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/tensor_element_owner_rank.sv =====
`timescale 1ns / 1ps
// owner rank of a sparse-tensor element under a balanced block distribution
// throughput: one item per cycle while the result is not held; 31 length/grid division cells, 7 index
// division cells and one multiply-add stage per dimension, all in one chain
// reset: rst_n clears the valid chain; every mode length and grid size reads 1
module tensor_element_owner_rank #(
  parameter int NUM_DIMS = teor_pkg::NUM_DIMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  teor_pkg::in_data_t       in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output teor_pkg::out_data_t      out_data,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [teor_pkg::AW-1:0]  cfg_paddr,
  input  logic [teor_pkg::DW-1:0]  cfg_pwdata,
  output logic [teor_pkg::DW-1:0]  cfg_prdata,
  output logic                     cfg_pready
);

  localparam int USED = (NUM_DIMS < teor_pkg::NUM_SLOTS) ? NUM_DIMS : teor_pkg::NUM_SLOTS;
  localparam int LAT  = teor_pkg::LW + 9 + USED;

  logic [teor_pkg::LW-1:0] mode_length_r [teor_pkg::NUM_SLOTS];
  logic [teor_pkg::GW-1:0] grid_size_r   [teor_pkg::NUM_SLOTS];
  logic [teor_pkg::LW-1:0] coord         [teor_pkg::NUM_SLOTS];
  logic [teor_pkg::IDXW-1:0] idx;
  logic en;
  logic [LAT-1:0] vld_r;

  teor_pkg::lane_res_t lres [USED];
  teor_pkg::lane_res_t hold_r [USED][USED];
  logic [teor_pkg::RW-1:0] rank_r [USED];
  logic                    bad_r  [USED];

  // configuration port
  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[teor_pkg::AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < teor_pkg::NUM_SLOTS; d++) begin
        mode_length_r[d] <= teor_pkg::LW'(1);
        grid_size_r[d]   <= teor_pkg::GW'(1);
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (idx < teor_pkg::REG_GRID_SIZE_0) begin
        mode_length_r[idx[1:0]] <= cfg_pwdata[teor_pkg::LW-1:0];
      end else begin
        grid_size_r[idx[1:0]] <= cfg_pwdata[teor_pkg::GW-1:0];
      end
    end
  end

  always_comb begin
    if (idx < teor_pkg::REG_GRID_SIZE_0) begin
      cfg_prdata = {{(teor_pkg::DW-teor_pkg::LW){1'b0}}, mode_length_r[idx[1:0]]};
    end else begin
      cfg_prdata = {{(teor_pkg::DW-teor_pkg::GW){1'b0}}, grid_size_r[idx[1:0]]};
    end
  end

  // whole chain advances unless the result register holds an untaken result
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign coord[0] = in_data.coord_0;
  assign coord[1] = in_data.coord_1;
  assign coord[2] = in_data.coord_2;
  assign coord[3] = in_data.coord_3;

  for (genvar d = 0; d < USED; d++) begin : g_lane
    teor_lane u_lane (
      .clk(clk), .en(en), .coord(coord[d]),
      .mode_length(mode_length_r[d]), .grid_size(grid_size_r[d]), .res(lres[d])
    );
  end

  // row-major combine, one multiply-add per stage
  for (genvar k = 0; k < USED; k++) begin : g_comb
    logic [teor_pkg::RW-1:0] rank_in;
    logic                    bad_in;
    teor_pkg::lane_res_t     src [USED];
    logic [teor_pkg::RW+teor_pkg::GW-1:0] prod;

    always_comb begin
      for (int d = 0; d < USED; d++) begin
        src[d] = (k == 0) ? lres[d] : hold_r[(k == 0) ? 0 : k-1][d];
      end
      if (k == 0) begin
        rank_in = '0;
        bad_in  = 1'b0;
        for (int d = 0; d < USED; d++) begin
          bad_in = bad_in | lres[d].bad;
        end
      end else begin
        rank_in = rank_r[(k == 0) ? 0 : k-1];
        bad_in  = bad_r[(k == 0) ? 0 : k-1];
      end
      prod = rank_in * src[k].grid + {{teor_pkg::RW{1'b0}}, src[k].blk};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rank_r[k] <= prod[teor_pkg::RW-1:0];
        bad_r[k]  <= bad_in;
        hold_r[k] <= src;
      end
    end
  end

  assign out_valid             = vld_r[LAT-1];
  assign out_data.out_of_range = bad_r[USED-1];
  assign out_data.owner_rank   = bad_r[USED-1] ? '0 : rank_r[USED-1];

  a_bad_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.out_of_range || out_data.owner_rank == '0))
    else $error("flagged result carries a nonzero rank");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (vld_r == '0))
    else $error("valid chain not empty after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("chain moved while the result was held");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && in_valid) |=> $stable(vld_r[0]))
    else $error("input taken while the result was held");

endmodule

// ===== tb/owner_rank_checker.sv =====
`timescale 1ns / 1ps
// checker: predicts the owner rank of every input transfer and compares results
module owner_rank_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  teor_pkg::in_data_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  teor_pkg::out_data_t           out_data,
  input  logic [teor_pkg::LW-1:0]       mode_len [4],
  input  logic [teor_pkg::GW-1:0]       grid_sz [4],
  output int                            fail_count,
  output int                            pending,
  output int                            result_count
);

  teor_pkg::out_data_t rank_queue[$];

  function automatic logic [63:0] block_index(logic [63:0] e, logic [63:0] len,
                                              logic [63:0] procs);
    logic [63:0] q, r, boundary;
    if (procs == 0) procs = 1;
    q = len / procs;
    r = len % procs;
    if (q == 0) return 0;
    boundary = r * (q + 1);
    if (e < boundary) return e / (q + 1);
    return r + (e - boundary) / q;
  endfunction

  function automatic teor_pkg::out_data_t owner_of(teor_pkg::in_data_t c);
    logic [63:0] rank, e, p;
    logic bad;
    logic [teor_pkg::LW-1:0] coords [4];
    teor_pkg::out_data_t res;
    coords = '{c.coord_0, c.coord_1, c.coord_2, c.coord_3};
    rank = 0;
    bad = 0;
    for (int d = 0; d < teor_pkg::NUM_SLOTS; d++) begin
      e = 64'(coords[d]);
      p = (grid_sz[d] == 0) ? 64'd1 : 64'(grid_sz[d]);
      if (e >= 64'(mode_len[d])) begin
        bad = 1;
      end else begin
        rank = (rank * p + block_index(e, 64'(mode_len[d]), p)) & 64'hFFFFFF;
      end
    end
    res.owner_rank = bad ? '0 : rank[teor_pkg::RW-1:0];
    res.out_of_range = bad;
    return res;
  endfunction

  always @(posedge clk) begin
    teor_pkg::out_data_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall) rank_queue = {rank_queue, owner_of(in_data)};
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (rank_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          errs = errs + 1;
        end else begin
          want = rank_queue.pop_front();
          if (out_data.owner_rank !== want.owner_rank) begin
            $error("owner_rank: expected %0d, got %0d", want.owner_rank, out_data.owner_rank);
            errs = errs + 1;
          end
          if (out_data.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                   out_data.out_of_range);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= rank_queue.size();
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top: drives coordinates and register writes, gives the verdict
module testbench;

  localparam int LATENCY = 44;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  teor_pkg::in_data_t in_data;
  teor_pkg::out_data_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [teor_pkg::AW-1:0] cfg_paddr;
  logic [teor_pkg::DW-1:0] cfg_pwdata, cfg_prdata;
  logic [30:0] mode_len [4];
  logic [6:0] grid_sz [4];
  int fail_count, pending, result_count, phase_count;
  longint cycles;

  tensor_element_owner_rank u_dut (.*);

  owner_rank_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // result side raises out_stall at random before each transfer, or not at all
  initial begin
    int gap;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      out_stall <= (gap != 0);
      if (gap != 0) begin
        repeat (gap) @(negedge clk);
        out_stall <= 0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic write_reg(int idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= teor_pkg::AW'(4 * idx); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    if (idx < int'(teor_pkg::REG_GRID_SIZE_0))
      mode_len[idx - int'(teor_pkg::REG_MODE_LENGTH_0)] = val[30:0];
    else grid_sz[idx - int'(teor_pkg::REG_GRID_SIZE_0)] = val[6:0];
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic set_length(int d, logic [31:0] val);
    write_reg(int'(teor_pkg::REG_MODE_LENGTH_0) + d, val);
  endtask

  task automatic set_grid(int d, logic [31:0] val);
    write_reg(int'(teor_pkg::REG_GRID_SIZE_0) + d, val);
  endtask

  task automatic send(teor_pkg::in_data_t c, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_coord(int d);
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return mode_len[d] - 31'd1;
      2: return mode_len[d];
      3: return 31'($urandom);
      default: return (mode_len[d] == 0) ? 31'd0 : 31'($urandom % mode_len[d]);
    endcase
  endfunction

  task automatic random_lengths(bit extreme);
    logic [31:0] v;
    for (int d = 0; d < 4; d++) begin
      case (extreme ? 0 : $urandom_range(0, 3))
        0: v = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h1;
        1: v = $urandom_range(1, 100);
        2: v = $urandom;
        default: v = $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
      endcase
      set_length(d, v);
      set_grid(d, extreme ? ($urandom_range(0, 1) ? 127 : 64) : $urandom_range(0, 127));
    end
  endtask

  initial begin
    teor_pkg::in_data_t c;
    bit burst;
    rst_n = 0; in_valid = 0; in_data = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    cycles = 0; phase_count = 0;
    for (int d = 0; d < 4; d++) begin
      mode_len[d] = 1;
      grid_sz[d] = 1;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset values: only the all-zero point is in range
    send('0, 0);
    send('{31'h7FFFFFFE, 0, 0, 0}, 0);
    drain();
    // more grid positions than indices, and zero grid / zero length
    set_length(0, 5);  set_grid(0, 8);
    set_length(1, 10); set_grid(1, 3);
    set_length(2, 0);  set_grid(2, 0);
    set_length(3, 7);  set_grid(3, 2);
    send('{4, 9, 0, 6}, 1);
    send('{0, 3, 0, 0}, 1);
    drain();
    set_length(2, 13);
    for (int i = 0; i < 13; i++) send('{i % 5, i % 10, i, i % 7}, i[0]);
    drain();
    // widest lengths, largest grids
    for (int d = 0; d < 4; d++) begin
      set_length(d, 32'h7FFFFFFF); set_grid(d, 127);
    end
    send('{31'h7FFFFFFE, 31'h7FFFFFFE, 31'h7FFFFFFE, 31'h7FFFFFFE}, 0);
    send('{31'h7FFFFFFF, 0, 0, 0}, 0);
    send('{0, 31'h40000000, 31'h55555555, 31'h2AAAAAAA}, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      phase_count++;
      random_lengths(ph == 0);
      for (int i = 0; i < 50; i++) begin
        burst = (i % 16) < 6;
        c.coord_0 = pick_coord(0);
        c.coord_1 = pick_coord(1);
        c.coord_2 = pick_coord(2);
        c.coord_3 = pick_coord(3);
        send(c, burst);
      end
      drain();
    end

    $display("ran %0d results over %0d random register settings plus directed corners",
             result_count, phase_count);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
